/* rtl/plb_pkg.sv */
package plb_pkg;

  localparam int PB = 16;
  localparam int PIPE_N = PB + 7;
  localparam int MUL_LAT = 4;
  localparam int PD_N = PB - MUL_LAT;

  typedef logic [PB-1:0] pix_t;
  typedef logic [2*PB-1:0] wide_t;

  localparam pix_t FULL = {PB{1'b1}};
  localparam pix_t HALF = FULL >> 1;

  typedef logic [2:0] mode_t;
  localparam mode_t MODE_NORMAL   = 3'd0;
  localparam mode_t MODE_ADD      = 3'd1;
  localparam mode_t MODE_SUBTRACT = 3'd2;
  localparam mode_t MODE_MULTIPLY = 3'd3;
  localparam mode_t MODE_SCREEN   = 3'd4;
  localparam mode_t MODE_OVERLAY  = 3'd5;
  localparam mode_t MODE_DIFF     = 3'd6;
  localparam mode_t MODE_DIVIDE   = 3'd7;

  typedef logic reg_idx_t;
  localparam reg_idx_t REG_MODE    = 1'b0;
  localparam reg_idx_t REG_OPACITY = 1'b1;

  typedef struct packed {
    mode_t mode;
    pix_t  a;
    pix_t  b;
    logic  inv;
    logic  dspec;
    pix_t  dspec_val;
  } prep_t;

endpackage

/* rtl/plb_prep.sv */
module plb_prep import plb_pkg::*; (
  input  logic  clk,
  input  logic  en,
  input  mode_t mode,
  input  pix_t  opacity,
  input  pix_t  a,
  input  pix_t  b,
  output prep_t prep_r,
  output pix_t  mx_r,
  output pix_t  my_r,
  output wide_t num_r,
  output pix_t  den_r
);

  prep_t prep_nxt;
  pix_t  mx_nxt;
  pix_t  my_nxt;
  wide_t num_nxt;

  always_comb begin
    prep_nxt.mode = mode;
    prep_nxt.a = a;
    prep_nxt.b = b;
    prep_nxt.inv = 1'b0;
    prep_nxt.dspec = (b == '0) || (a >= b);
    prep_nxt.dspec_val = ((a == '0) && (b == '0)) ? '0 : FULL;
    mx_nxt = a;
    my_nxt = b;
    unique case (mode)
      MODE_ADD, MODE_SUBTRACT: begin
        mx_nxt = b;
        my_nxt = opacity;
      end
      MODE_SCREEN: begin
        mx_nxt = FULL - a;
        my_nxt = FULL - b;
        prep_nxt.inv = 1'b1;
      end
      MODE_OVERLAY: begin
        if (a <= HALF) begin
          mx_nxt = {a[PB-2:0], 1'b0};
        end else begin
          mx_nxt = pix_t'({(FULL - a), 1'b0});
          my_nxt = FULL - b;
          prep_nxt.inv = 1'b1;
        end
      end
      default: begin
        mx_nxt = a;
        my_nxt = b;
      end
    endcase
    // a*full + b/2, full scale being 2^n - 1
    num_nxt = {a, {PB{1'b0}}} - {{PB{1'b0}}, a} + {{(PB+1){1'b0}}, b[PB-1:1]};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prep_r <= prep_nxt;
      mx_r <= mx_nxt;
      my_r <= my_nxt;
      num_r <= num_nxt;
      den_r <= b;
    end
  end

endmodule

/* rtl/plb_frac_mul.sv */
module plb_frac_mul import plb_pkg::*; (
  input  logic clk,
  input  logic en,
  input  pix_t x1,
  input  pix_t y1,
  input  pix_t x2,
  input  pix_t y2,
  output pix_t q_r
);

  wide_t            p1_r;
  wide_t            p2_r;
  wide_t            s_r;
  pix_t             q0_r;
  logic [PB+1:0]    sl_r;
  wide_t            s_nxt;
  logic [2*PB:0]    est;
  pix_t             q0_nxt;
  logic [PB+1:0]    rem;
  pix_t             q_nxt;

  always_comb begin
    s_nxt = p1_r + p2_r + {{PB{1'b0}}, HALF};
    // estimate of s / full scale, never above the true quotient and at most one below
    est = {1'b0, s_r} + {{(PB+1){1'b0}}, s_r[2*PB-1:PB]};
    q0_nxt = est[2*PB-1:PB];
    rem = sl_r - {q0_r[1:0], {PB{1'b0}}} + {2'b00, q0_r};
    q_nxt = q0_r + pix_t'(rem >= {2'b00, FULL});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_r <= x1 * y1;
      p2_r <= x2 * y2;
      s_r <= s_nxt;
      q0_r <= q0_nxt;
      sl_r <= s_r[PB+1:0];
      q_r <= q_nxt;
    end
  end

endmodule

/* rtl/plb_div.sv */
module plb_div import plb_pkg::*; (
  input  logic  clk,
  input  logic  en,
  input  wide_t num,
  input  pix_t  den,
  output pix_t  q
);

  pix_t rem_r [PB];
  pix_t low_r [PB];
  pix_t q_r [PB];
  pix_t den_r [PB];
  pix_t rem_nxt [PB];
  pix_t low_nxt [PB];
  pix_t q_nxt [PB];
  pix_t den_nxt [PB];

  always_comb begin
    for (int i = 0; i < PB; i++) begin
      pix_t rem_c;
      pix_t low_c;
      pix_t q_c;
      pix_t den_c;
      logic [PB:0] trial;
      logic ge;
      if (i == 0) begin
        rem_c = num[2*PB-1:PB];
        low_c = num[PB-1:0];
        q_c = '0;
        den_c = den;
      end else begin
        rem_c = rem_r[i-1];
        low_c = low_r[i-1];
        q_c = q_r[i-1];
        den_c = den_r[i-1];
      end
      trial = {rem_c, low_c[PB-1]};
      ge = trial >= {1'b0, den_c};
      rem_nxt[i] = ge ? pix_t'(trial - {1'b0, den_c}) : trial[PB-1:0];
      low_nxt[i] = {low_c[PB-2:0], 1'b0};
      q_nxt[i] = {q_c[PB-2:0], ge};
      den_nxt[i] = den_c;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < PB; i++) begin
        rem_r[i] <= rem_nxt[i];
        low_r[i] <= low_nxt[i];
        q_r[i] <= q_nxt[i];
        den_r[i] <= den_nxt[i];
      end
    end
  end

  assign q = q_r[PB-1];

endmodule

/* rtl/pixel_layer_blend.sv */
// pixel_layer_blend: blends a base sample with a blend-layer sample.
// input channel: in_valid / in_stall carry in_base_pixel and in_blend_pixel,
// one beat per pixel. result channel: out_valid / out_stall carry
// out_result_pixel, one beat for every input beat, in order.
// configuration: cfg_we writes cfg_wdata into register cfg_index
// (0 blend mode, 1 opacity); write only while no pixel is in flight.
// pipeline depth (16-bit samples) is set by the divider, which resolves
// one quotient bit per stage.
// throughput: one pixel per clock in every mode while the receiver does not stall a waiting result.
// reset (rst_n low, synchronous): pipeline emptied, mode normal, opacity 0.
// when the receiver stalls a waiting result, the whole pipeline holds
// and in_stall rises in the same cycle; nothing is dropped or repeated.
module pixel_layer_blend import plb_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  pix_t     in_base_pixel,
  input  pix_t     in_blend_pixel,
  output logic     out_valid,
  input  logic     out_stall,
  output pix_t     out_result_pixel,
  input  logic     cfg_we,
  input  reg_idx_t cfg_index,
  input  pix_t     cfg_wdata
);

  logic  en;
  mode_t mode_r;
  pix_t  opacity_r;
  logic  vld_r [PIPE_N];
  logic  out_valid_r;
  pix_t  out_result_r;
  pix_t  a1_r;
  pix_t  b1_r;
  prep_t prep;
  pix_t  mx;
  pix_t  my;
  wide_t num;
  pix_t  den;
  pix_t  prod;
  pix_t  dq;
  pix_t  pd_r [PD_N];
  prep_t pp_r [PB];
  prep_t pa;
  pix_t  pprod;
  pix_t  t_nxt;
  logic  as_nxt;
  pix_t  asv_nxt;
  logic [PB:0] sum;
  pix_t  t_r;
  pix_t  at_r;
  logic  as_r;
  pix_t  asv_r;
  logic  asd_r [MUL_LAT];
  pix_t  asvd_r [MUL_LAT];
  pix_t  mix;

  assign en = !out_valid_r || !out_stall;
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_NORMAL;
      opacity_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MODE:    mode_r <= cfg_wdata[2:0];
        REG_OPACITY: opacity_r <= cfg_wdata;
        default:     mode_r <= mode_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < PIPE_N; i++) vld_r[i] <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_valid;
      for (int i = 1; i < PIPE_N; i++) vld_r[i] <= vld_r[i-1];
      out_valid_r <= vld_r[PIPE_N-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a1_r <= in_base_pixel;
      b1_r <= in_blend_pixel;
    end
  end

  plb_prep u_prep (
    .clk(clk), .en(en), .mode(mode_r), .opacity(opacity_r),
    .a(a1_r), .b(b1_r), .prep_r(prep), .mx_r(mx), .my_r(my),
    .num_r(num), .den_r(den)
  );

  plb_frac_mul u_tmul (
    .clk(clk), .en(en), .x1(mx), .y1(my), .x2('0), .y2('0), .q_r(prod)
  );

  plb_div u_div (
    .clk(clk), .en(en), .num(num), .den(den), .q(dq)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      pd_r[0] <= prod;
      for (int i = 1; i < PD_N; i++) pd_r[i] <= pd_r[i-1];
      pp_r[0] <= prep;
      for (int i = 1; i < PB; i++) pp_r[i] <= pp_r[i-1];
    end
  end

  assign pa = pp_r[PB-1];
  assign pprod = pd_r[PD_N-1];

  always_comb begin
    as_nxt = 1'b0;
    sum = {1'b0, pa.a} + {1'b0, pprod};
    asv_nxt = '0;
    t_nxt = pa.b;
    unique case (pa.mode)
      MODE_ADD: begin
        as_nxt = 1'b1;
        asv_nxt = sum[PB] ? FULL : sum[PB-1:0];
      end
      MODE_SUBTRACT: begin
        as_nxt = 1'b1;
        asv_nxt = (pprod > pa.a) ? '0 : pa.a - pprod;
      end
      MODE_MULTIPLY, MODE_SCREEN, MODE_OVERLAY: t_nxt = pa.inv ? FULL - pprod : pprod;
      MODE_DIFF:   t_nxt = (pa.a >= pa.b) ? pa.a - pa.b : pa.b - pa.a;
      MODE_DIVIDE: t_nxt = pa.dspec ? pa.dspec_val : dq;
      default:     t_nxt = pa.b;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t_r <= t_nxt;
      at_r <= pa.a;
      as_r <= as_nxt;
      asv_r <= asv_nxt;
      asd_r[0] <= as_r;
      asvd_r[0] <= asv_r;
      for (int i = 1; i < MUL_LAT; i++) begin
        asd_r[i] <= asd_r[i-1];
        asvd_r[i] <= asvd_r[i-1];
      end
      out_result_r <= asd_r[MUL_LAT-1] ? asvd_r[MUL_LAT-1] : mix;
    end
  end

  plb_frac_mul u_mix (
    .clk(clk), .en(en), .x1(at_r), .y1(FULL - opacity_r), .x2(t_r), .y2(opacity_r),
    .q_r(mix)
  );

  assign out_valid = out_valid_r;
  assign out_result_pixel = out_result_r;

endmodule

/* rtl/plb_checker.sv */
module plb_port_checker import plb_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input pix_t out_result_pixel
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_result_pixel))
    else $error("stalled result changed");

  a_stall_link: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (out_valid && out_stall))
    else $error("input stall does not follow the waiting result");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result beat right after reset");

endmodule

bind pixel_layer_blend plb_port_checker u_plb_checker (
  .clk(clk), .rst_n(rst_n), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_result_pixel(out_result_pixel)
);

/* verif/plb_checker.sv */
module plb_checker import plb_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_stall,
  input  pix_t     in_base_pixel,
  input  pix_t     in_blend_pixel,
  input  logic     out_valid,
  input  logic     out_stall,
  input  pix_t     out_result_pixel,
  input  logic     cfg_we,
  input  reg_idx_t cfg_index,
  input  pix_t     cfg_wdata,
  output int       fail_count,
  output int       pending
);

  localparam longint unsigned FS = (64'd1 << PB) - 1;

  mode_t cur_mode;
  pix_t  cur_opacity;
  pix_t  expected_pixels[$];

  assign pending = expected_pixels.size();

  function automatic longint unsigned fmul(longint unsigned x, longint unsigned y);
    return (x * y + (FS >> 1)) / FS;
  endfunction

  function automatic pix_t blend_pixel(mode_t m, pix_t op, pix_t base, pix_t blend);
    longint unsigned a, b, o, t, v;
    a = base;
    b = blend;
    o = op;
    t = b;
    case (m)
      MODE_ADD: begin
        v = a + fmul(b, o);
        return (v > FS) ? pix_t'(FS) : pix_t'(v);
      end
      MODE_SUBTRACT: begin
        t = fmul(b, o);
        return (t > a) ? pix_t'(0) : pix_t'(a - t);
      end
      MODE_MULTIPLY: t = fmul(a, b);
      MODE_SCREEN:   t = FS - fmul(FS - a, FS - b);
      MODE_OVERLAY: begin
        if (2 * a <= FS) t = fmul(2 * a, b);
        else t = FS - fmul(2 * (FS - a), FS - b);
      end
      MODE_DIFF:     t = (a >= b) ? a - b : b - a;
      MODE_DIVIDE: begin
        if (b == 0) t = (a == 0) ? 0 : FS;
        else begin
          t = (a * FS + (b >> 1)) / b;
          if (t > FS) t = FS;
        end
      end
      default:       t = b;
    endcase
    v = (a * (FS - o) + t * o + (FS >> 1)) / FS;
    return (v > FS) ? pix_t'(FS) : pix_t'(v);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      cur_mode <= MODE_NORMAL;
      cur_opacity <= '0;
      fail_count <= 0;
      expected_pixels.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_MODE) cur_mode <= mode_t'(cfg_wdata);
        else cur_opacity <= cfg_wdata;
      end
      if (in_valid && !in_stall)
        expected_pixels.push_back(blend_pixel(cur_mode, cur_opacity, in_base_pixel,
                                              in_blend_pixel));
      if (out_valid && !out_stall) begin
        if (expected_pixels.size() == 0) begin
          if (fail_count < 10) $display("unexpected beat: %h", out_result_pixel);
          fail_count <= fail_count + 1;
        end else begin
          if (expected_pixels[0] !== out_result_pixel) begin
            if (fail_count < 10)
              $display("result_pixel: expected %h actual %h", expected_pixels[0],
                       out_result_pixel);
            fail_count <= fail_count + 1;
          end
          void'(expected_pixels.pop_front());
        end
      end
    end
  end

endmodule

/* verif/tb_top.sv */
module tb_top;
  import plb_pkg::*;

  logic     clk = 0;
  logic     rst_n = 0;
  logic     in_valid = 0;
  logic     in_stall;
  pix_t     in_base_pixel = '0;
  pix_t     in_blend_pixel = '0;
  logic     out_valid;
  logic     out_stall = 0;
  pix_t     out_result_pixel;
  logic     cfg_we = 0;
  reg_idx_t cfg_index = REG_MODE;
  pix_t     cfg_wdata = '0;
  int       fail_count;
  int       pending;
  bit       calm = 0;

  always #2 clk = ~clk;

  pixel_layer_blend u_dut (.*);

  plb_checker u_chk (.*);

  initial begin
    #2000000;
    $display("pixel_layer_blend: mismatch");
    $finish;
  end

  // receiver stall bursts
  initial begin
    int n;
    forever begin
      n = $urandom_range(1, 10);
      if (!calm && $urandom_range(0, 2) == 0) begin
        out_stall <= 1;
        repeat (n) @(posedge clk);
      end else begin
        out_stall <= 0;
        repeat (n) @(posedge clk);
      end
    end
  end

  function automatic pix_t edge_pick();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return FULL;
      2: return HALF;
      3: return HALF + 1'b1;
      default: return pix_t'($urandom);
    endcase
  endfunction

  task automatic send_pixel(pix_t a, pix_t b);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid <= 1;
    in_base_pixel <= a;
    in_blend_pixel <= b;
    @(posedge clk iff !in_stall);
  endtask

  task automatic write_reg(reg_idx_t idx, pix_t val);
    in_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 0;
  endtask

  initial begin
    pix_t ops[4];
    ops = '{16'h0000, 16'hFFFF, 16'h8000, 16'h7FFF};
    repeat (12) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    send_pixel(16'h1234, 16'hABCD);
    // directed: extremes in each mode at full opacity
    write_reg(REG_OPACITY, FULL);
    for (int m = 0; m < 8; m++) begin
      write_reg(REG_MODE, pix_t'(m));
      send_pixel('0, '0);
      send_pixel(FULL, FULL);
      send_pixel(16'h4000, '0);
      send_pixel(HALF, 16'h9000);
      send_pixel(HALF + 1'b1, 16'h3000);
    end
    for (int ph = 0; ph < 24; ph++) begin
      if (ph == 20) calm = 1;
      write_reg(REG_MODE, pix_t'(ph % 8));
      write_reg(REG_OPACITY, (ph < 4) ? ops[ph] : pix_t'($urandom));
      for (int i = 0; i < 36; i++) send_pixel(edge_pick(), edge_pick());
    end
    in_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0) $display("pixel_layer_blend: match");
    else $display("pixel_layer_blend: mismatch");
    $finish;
  end

endmodule
